// ===== rtl/core/sptf_pkg.sv =====
// Shared types and constants for the shortest-job-first queue server.
package sptf_pkg;
  localparam int DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int TAG_W = 16;
  localparam int CNT_W = 5;
  localparam logic MODE_ARRIVE = 1'b0;
  localparam logic MODE_COMPLETE = 1'b1;

  typedef struct packed {
    logic load;
    logic insert;
    logic pop;
  } sptf_cmd_t;
endpackage

// ===== rtl/core/sptf_if.sv =====
// Valid/ready channel interfaces for events, results and configuration.
interface sptf_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] job_id;
  logic [31:0] processing_time;
  logic [31:0] now;
  modport source(output valid, mode, job_id, processing_time, now, input ready);
  modport sink(input valid, mode, job_id, processing_time, now, output ready);
endinterface

interface sptf_out_if;
  logic        valid;
  logic        ready;
  logic        done_valid;
  logic [15:0] done_id;
  logic [31:0] response_time;
  logic        start_valid;
  logic [15:0] start_id;
  logic [31:0] start_service_time;
  logic [31:0] waiting_time;
  logic [4:0]  queue_length;
  logic        server_busy;
  logic [31:0] total_busy_time;
  logic        dropped;
  logic        error;
  modport source(output valid, done_valid, done_id, response_time, start_valid, start_id,
    start_service_time, waiting_time, queue_length, server_busy, total_busy_time,
    dropped, error, input ready);
  modport sink(input valid, done_valid, done_id, response_time, start_valid, start_id,
    start_service_time, waiting_time, queue_length, server_busy, total_busy_time,
    dropped, error, output ready);
endinterface

interface sptf_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== rtl/core/sptf_queue_server_top.sv =====
// Shortest-job-first single-server scheduler, top level.
// An event is captured at its transfer and executed in the next cycle;
// the result is valid from the edge after the transfer.
// No new event is taken while one executes (S_EXEC); a waiting
// result holds off the next event, which can transfer in the cycle it is taken.
// Reset (rst, synchronous): server idle, queue empty, busy total zero, limit 16.
module sptf_queue_server_top #(
  parameter int DEPTH = sptf_pkg::DEPTH_DEF,
  parameter int TIME_BITS = sptf_pkg::TIME_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  sptf_in_if.sink   evt,
  sptf_out_if.source res,
  sptf_cfg_if.sink  cfg
);
  import sptf_pkg::*;
  sptf_cmd_t            cmd;
  logic [15:0]          q_tag, head_tag;
  logic [TIME_BITS-1:0] q_svc, q_arr, head_svc, head_arr;
  logic [$clog2(DEPTH+1)-1:0] count;

  sptf_ctrl #(.DEPTH(DEPTH), .TIME_BITS(TIME_BITS)) u_ctrl (
    .clk, .rst, .evt, .res, .cfg, .cmd, .q_tag, .q_svc, .q_arr,
    .head_tag, .head_svc, .head_arr, .count);

  sptf_queue #(.DEPTH(DEPTH), .TIME_BITS(TIME_BITS)) u_queue (
    .clk, .rst, .cmd, .in_tag(q_tag), .in_svc(q_svc), .in_arr(q_arr),
    .head_tag, .head_svc, .head_arr, .count);
endmodule

// ===== rtl/core/sptf_queue.sv =====
// Sorted shift-register wait queue with insert and pop.
module sptf_queue #(
  parameter int DEPTH = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sptf_pkg::sptf_cmd_t  cmd,
  input  logic [15:0]          in_tag,
  input  logic [TIME_BITS-1:0] in_svc,
  input  logic [TIME_BITS-1:0] in_arr,
  output logic [15:0]          head_tag,
  output logic [TIME_BITS-1:0] head_svc,
  output logic [TIME_BITS-1:0] head_arr,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import sptf_pkg::*;
  localparam int CW = $clog2(DEPTH+1);
  logic [15:0]          tag [DEPTH];
  logic [TIME_BITS-1:0] svc [DEPTH];
  logic [TIME_BITS-1:0] arr [DEPTH];
  logic [DEPTH-1:0]     gt;

  // gt[i]: occupied entry whose time exceeds the new one; sorted, so a thermometer
  always_comb begin
    for (int i = 0; i < DEPTH; i++)
      gt[i] = (CW'(i) < count) && (svc[i] > in_svc);
  end

  assign head_tag = tag[0];
  assign head_svc = svc[0];
  assign head_arr = arr[0];

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd.insert) begin
        if (gt[i]) begin
          if (i > 0 && !gt[(i > 0) ? i-1 : 0]) begin
            tag[i] <= in_tag; svc[i] <= in_svc; arr[i] <= in_arr;
          end else if (i > 0) begin
            tag[i] <= tag[(i > 0) ? i-1 : 0];
            svc[i] <= svc[(i > 0) ? i-1 : 0];
            arr[i] <= arr[(i > 0) ? i-1 : 0];
          end else begin
            tag[i] <= in_tag; svc[i] <= in_svc; arr[i] <= in_arr;
          end
        end else if (CW'(i) == count) begin
          if (i > 0 && gt[(i > 0) ? i-1 : 0]) begin
            tag[i] <= tag[(i > 0) ? i-1 : 0];
            svc[i] <= svc[(i > 0) ? i-1 : 0];
            arr[i] <= arr[(i > 0) ? i-1 : 0];
          end else begin
            tag[i] <= in_tag; svc[i] <= in_svc; arr[i] <= in_arr;
          end
        end
      end else if (cmd.pop && i < DEPTH-1) begin
        tag[i] <= tag[(i < DEPTH-1) ? i+1 : i];
        svc[i] <= svc[(i < DEPTH-1) ? i+1 : i];
        arr[i] <= arr[(i < DEPTH-1) ? i+1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.insert) begin
      count <= count + 1'b1;
    end else if (cmd.pop) begin
      count <= count - 1'b1;
    end
  end
endmodule

// ===== rtl/core/sptf_ctrl.sv =====
// Event controller: decides the action, updates server state, builds the result.
module sptf_ctrl #(
  parameter int DEPTH = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  sptf_in_if.sink              evt,
  sptf_out_if.source           res,
  sptf_cfg_if.sink             cfg,
  output sptf_pkg::sptf_cmd_t  cmd,
  output logic [15:0]          q_tag,
  output logic [TIME_BITS-1:0] q_svc,
  output logic [TIME_BITS-1:0] q_arr,
  input  logic [15:0]          head_tag,
  input  logic [TIME_BITS-1:0] head_svc,
  input  logic [TIME_BITS-1:0] head_arr,
  input  logic [$clog2(DEPTH+1)-1:0] count
);
  import sptf_pkg::*;
  localparam int CW = $clog2(DEPTH+1);
  localparam int LW = (CW + 1 > CNT_W) ? CW + 1 : CNT_W;

  typedef enum logic [1:0] {S_IDLE = 2'b01, S_EXEC = 2'b10} state_t;
  state_t state;

  logic [CNT_W-1:0]     queue_limit;
  logic                 mode_r;
  logic [15:0]          tag_r;
  logic [TIME_BITS-1:0] pt_r, now_r;
  logic                 serving_valid;
  logic [15:0]          serving_tag;
  logic [TIME_BITS-1:0] serving_arrival, busy_since, busy_total;
  logic                 room;
  logic [LW-1:0]        lim_eff;
  logic [TIME_BITS-1:0] busy_total_next;

  logic                 done_valid_next;
  logic [15:0]          done_id_next;
  logic [31:0]          response_time_next;
  logic                 start_valid_next;
  logic [15:0]          start_id_next;
  logic [31:0]          start_service_time_next;
  logic [31:0]          waiting_time_next;
  logic [4:0]           queue_length_next;
  logic                 server_busy_next;
  logic [31:0]          total_busy_time_next;
  logic                 dropped_next;
  logic                 error_next;

  assign cfg.ready = 1'b1;
  // Accept a new event when idle and no result waits, or in the cycle the previous result transfers
  assign evt.ready = (state == S_IDLE) && (!res.valid || res.ready);
  assign lim_eff = (LW'(queue_limit) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(queue_limit);
  assign room = LW'(count) < lim_eff;
  assign busy_total_next = busy_total + (now_r - busy_since);

  assign q_tag = tag_r;
  assign q_svc = pt_r;
  assign q_arr = now_r;

  always_comb begin
    cmd = '0;
    if (state == S_EXEC) begin
      cmd.insert = (mode_r == MODE_ARRIVE) && serving_valid && room;
      cmd.pop = (mode_r == MODE_COMPLETE) && serving_valid && (count != '0);
    end
  end

  always_comb begin
    done_valid_next = 1'b0;
    done_id_next = '0;
    response_time_next = '0;
    start_valid_next = 1'b0;
    start_id_next = '0;
    start_service_time_next = '0;
    waiting_time_next = '0;
    queue_length_next = 5'(count);
    server_busy_next = serving_valid;
    total_busy_time_next = 32'(busy_total);
    dropped_next = 1'b0;
    error_next = 1'b0;
    if (mode_r == MODE_ARRIVE) begin
      if (!serving_valid) begin
        start_valid_next = 1'b1;
        start_id_next = tag_r;
        start_service_time_next = 32'(pt_r);
        server_busy_next = 1'b1;
      end else if (room) begin
        queue_length_next = 5'(count + 1'b1);
      end else begin
        dropped_next = 1'b1;
      end
    end else if (!serving_valid) begin
      error_next = 1'b1;
    end else begin
      done_valid_next = 1'b1;
      done_id_next = serving_tag;
      response_time_next = 32'(now_r - serving_arrival);
      if (count != '0) begin
        start_valid_next = 1'b1;
        start_id_next = head_tag;
        start_service_time_next = 32'(head_svc);
        waiting_time_next = 32'(now_r - head_arr);
        queue_length_next = 5'(count - 1'b1);
      end else begin
        total_busy_time_next = 32'(busy_total_next);
        server_busy_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      mode_r <= evt.mode;
      tag_r <= evt.job_id;
      pt_r <= TIME_BITS'(evt.processing_time);
      now_r <= TIME_BITS'(evt.now);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      queue_limit <= 5'd16;
      res.valid <= 1'b0;
      serving_valid <= 1'b0;
      serving_tag <= '0;
      serving_arrival <= '0;
      busy_since <= '0;
      busy_total <= '0;
    end else begin
      if (cfg.valid && cfg.ready) queue_limit <= cfg.data;
      if (state == S_EXEC) res.valid <= 1'b1;
      else if (res.ready) res.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (evt.valid && evt.ready) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_IDLE;
          res.done_valid <= done_valid_next;
          res.done_id <= done_id_next;
          res.response_time <= response_time_next;
          res.start_valid <= start_valid_next;
          res.start_id <= start_id_next;
          res.start_service_time <= start_service_time_next;
          res.waiting_time <= waiting_time_next;
          res.queue_length <= queue_length_next;
          res.server_busy <= server_busy_next;
          res.total_busy_time <= total_busy_time_next;
          res.dropped <= dropped_next;
          res.error <= error_next;
          if (mode_r == MODE_ARRIVE) begin
            if (!serving_valid) begin
              serving_valid <= 1'b1;
              serving_tag <= tag_r;
              serving_arrival <= now_r;
              busy_since <= now_r;
            end
          end else if (serving_valid) begin
            if (count != '0) begin
              serving_tag <= head_tag;
              serving_arrival <= head_arr;
            end else begin
              serving_valid <= 1'b0;
              serving_tag <= '0;
              serving_arrival <= '0;
              busy_since <= '0;
              busy_total <= busy_total_next;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
